### design/lob_pkg.sv
// Package for the limit order book: payload structs, status and function codes,
// sequencer states. No dependencies.
`timescale 1ns / 1ps
package lob_pkg;

   typedef enum logic [1:0] {
      FN_ADD    = 2'd0,
      FN_CANCEL = 2'd1,
      FN_EXEC   = 2'd2,
      FN_QUERY  = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_BAD_ID    = 3'd1,
      ST_BAD_PRICE = 3'd2,
      ST_BAD_QTY   = 3'd3,
      ST_DUP       = 3'd4,
      ST_FULL      = 3'd5,
      ST_NOT_FOUND = 3'd6
   } status_type;

   localparam logic [0:0] CSR_BASE_PRICE  = 1'b0;
   localparam logic [0:0] CSR_PRICE_RANGE = 1'b1;
   localparam int unsigned CSR_WIDTH = 32;

   typedef struct packed {
      logic [1:0]  func;
      logic [11:0] order_id;
      logic        side;
      logic [31:0] price;
      logic [31:0] quantity;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] best_bid_price;
      logic        bid_present;
      logic [31:0] best_ask_price;
      logic        ask_present;
      logic [31:0] level_quantity;
   } rsp_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_READ,
      S_DECIDE,
      S_ORD_RD,
      S_LVL_RD,
      S_REMOVE,
      S_SCAN,
      S_SCAN_CHK,
      S_RESP
   } state_type;

endpackage

### design/limit_order_book.sv
// Limit order book top level: order table, per-side level totals, best price tracking.
// Depends on lob_pkg.
`timescale 1ns / 1ps
// Two-sided price-level book driven by one sequencer over single-port tables.
// When the best level of a side empties, a scan steps one level slot at a time
// through that side's level memory, away from the emptied slot. After reset a
// clearing pass over max(ORDER_SLOTS, PRICE_SPAN) addresses zeroes the live bits
// and level totals before the first request transfer is taken. Configuration writes
// are taken at any time and should only be made while the book is idle.
module limit_order_book #(
   parameter int unsigned ORDER_SLOTS = 1024,
   parameter int unsigned LEVEL_POOL  = 1024,
   parameter int unsigned PRICE_SPAN  = 1024
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  lob_pkg::req_type            req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output lob_pkg::rsp_type            rsp_data,
   input  logic                        csr_write,
   input  logic [0:0]                  csr_index,
   input  logic [lob_pkg::CSR_WIDTH-1:0] csr_data
);
   localparam int unsigned OW = (ORDER_SLOTS > 1) ? $clog2(ORDER_SLOTS) : 1;
   localparam int unsigned SW = (PRICE_SPAN > 1) ? $clog2(PRICE_SPAN) : 1;
   localparam int unsigned CLR_N = (ORDER_SLOTS > PRICE_SPAN) ? ORDER_SLOTS : PRICE_SPAN;
   localparam int unsigned CW = $clog2(CLR_N + 1);
   localparam int unsigned AW = $clog2(LEVEL_POOL + 1);

   // memories
   logic        live_mem [ORDER_SLOTS];
   logic [SW:0] oinfo_mem [ORDER_SLOTS]; // {side, slot}
   logic [31:0] orem_mem [ORDER_SLOTS];
   logic [31:0] bid_mem [PRICE_SPAN];
   logic [31:0] ask_mem [PRICE_SPAN];

   lob_pkg::state_type state_ff, state_in;
   logic [31:0] base_ff;
   logic [10:0] range_ff;
   lob_pkg::req_type req_ff, req_in;
   lob_pkg::rsp_type rsp_ff, rsp_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [CW-1:0] clr_ff, clr_in;
   logic [AW-1:0] act_ff, act_in;
   logic [SW:0] bbid_ff, bbid_in, bask_ff, bask_in;
   logic [SW-1:0] slot_ff, slot_in;
   logic side_ff, side_in;
   logic pok_ff, pok_in;
   logic [SW-1:0] scan_ff, scan_in;
   logic [2:0] status_ff, status_in;
   logic [31:0] lq_ff, lq_in;

   // read data registers
   logic        live_rd;
   logic [SW:0] oinfo_rd;
   logic [31:0] orem_rd, bid_rd, ask_rd;

   // memory control
   logic [OW-1:0] oaddr;
   logic          live_we, live_wd, oinfo_we, orem_we;
   logic [SW:0]   oinfo_wd;
   logic [31:0]   orem_wd;
   logic [SW-1:0] laddr;
   logic          bid_we, ask_we;
   logic [31:0]   lvl_wd;

   always_ff @(posedge clock) begin
      if (live_we) live_mem[oaddr] <= live_wd;
      live_rd <= live_mem[oaddr];
      if (oinfo_we) oinfo_mem[oaddr] <= oinfo_wd;
      oinfo_rd <= oinfo_mem[oaddr];
      if (orem_we) orem_mem[oaddr] <= orem_wd;
      orem_rd <= orem_mem[oaddr];
      if (bid_we) bid_mem[laddr] <= lvl_wd;
      bid_rd <= bid_mem[laddr];
      if (ask_we) ask_mem[laddr] <= lvl_wd;
      ask_rd <= ask_mem[laddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lob_pkg::S_CLEAR;
         base_ff      <= '0;
         range_ff     <= 11'd1024;
         rsp_valid_ff <= 1'b0;
         clr_ff       <= '0;
         act_ff       <= '0;
         bbid_ff      <= (SW+1)'(PRICE_SPAN);
         bask_ff      <= (SW+1)'(PRICE_SPAN);
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         clr_ff       <= clr_in;
         act_ff       <= act_in;
         bbid_ff      <= bbid_in;
         bask_ff      <= bask_in;
         if (csr_write) begin
            if (csr_index == lob_pkg::CSR_BASE_PRICE) base_ff <= csr_data;
            else range_ff <= csr_data[10:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      req_ff    <= req_in;
      rsp_ff    <= rsp_in;
      slot_ff   <= slot_in;
      side_ff   <= side_in;
      pok_ff    <= pok_in;
      scan_ff   <= scan_in;
      status_ff <= status_in;
      lq_ff     <= lq_in;
   end

   // price check on the held request
   logic [31:0] pdiff;
   logic [10:0] lim;
   logic        price_ok;
   always_comb begin
      pdiff = req_ff.price - base_ff;
      lim = (range_ff > 11'(PRICE_SPAN)) ? 11'(PRICE_SPAN) : range_ff;
      price_ok = (req_ff.price != 32'd0) && (req_ff.price != 32'hFFFF_FFFF)
                 && (req_ff.price >= base_ff) && (pdiff < {21'd0, lim});
   end

   logic [31:0] lvl_rd;
   logic [32:0] sum;
   logic [SW:0] none_mark;
   logic        id_bad;
   assign lvl_rd = side_ff ? ask_rd : bid_rd;
   assign sum = {1'b0, lvl_rd} + {1'b0, req_ff.quantity};
   assign none_mark = (SW+1)'(PRICE_SPAN);
   assign id_bad = {20'd0, req_ff.order_id} >= 32'(ORDER_SLOTS);

   always_comb begin
      logic [31:0] newtot;
      state_in = state_ff;
      req_in = req_ff;
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      clr_in = clr_ff;
      act_in = act_ff;
      bbid_in = bbid_ff;
      bask_in = bask_ff;
      slot_in = slot_ff;
      side_in = side_ff;
      pok_in = pok_ff;
      scan_in = scan_ff;
      status_in = status_ff;
      lq_in = lq_ff;
      oaddr = req_ff.order_id[OW-1:0];
      laddr = slot_ff;
      live_we = 1'b0;
      live_wd = 1'b0;
      oinfo_we = 1'b0;
      oinfo_wd = {side_ff, slot_ff};
      orem_we = 1'b0;
      orem_wd = req_ff.quantity;
      bid_we = 1'b0;
      ask_we = 1'b0;
      lvl_wd = '0;
      req_ready = 1'b0;
      newtot = '0;
      unique case (state_ff)
         lob_pkg::S_CLEAR: begin
            oaddr = clr_ff[OW-1:0];
            laddr = clr_ff[SW-1:0];
            live_we = clr_ff < CW'(ORDER_SLOTS);
            bid_we = clr_ff < CW'(PRICE_SPAN);
            ask_we = bid_we;
            clr_in = clr_ff + CW'(1);
            if (clr_ff == CW'(CLR_N - 1)) state_in = lob_pkg::S_IDLE;
         end
         lob_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               req_in = req_data;
               state_in = lob_pkg::S_READ;
            end
         end
         lob_pkg::S_READ: begin
            // issue order table read; compute slot
            slot_in = pdiff[SW-1:0];
            side_in = req_ff.side;
            pok_in = price_ok;
            lq_in = '0;
            state_in = lob_pkg::S_DECIDE;
         end
         lob_pkg::S_DECIDE: begin
            // order read data valid; level read issued at slot_ff
            unique case (lob_pkg::func_type'(req_ff.func))
               lob_pkg::FN_ADD: begin
                  if (id_bad) begin
                     status_in = lob_pkg::ST_BAD_ID;
                     state_in = lob_pkg::S_RESP;
                  end else if (!pok_ff) begin
                     status_in = lob_pkg::ST_BAD_PRICE;
                     state_in = lob_pkg::S_RESP;
                  end else if (req_ff.quantity == 32'd0) begin
                     status_in = lob_pkg::ST_BAD_QTY;
                     state_in = lob_pkg::S_RESP;
                  end else if (live_rd) begin
                     status_in = lob_pkg::ST_DUP;
                     state_in = lob_pkg::S_RESP;
                  end else state_in = lob_pkg::S_LVL_RD;
               end
               lob_pkg::FN_QUERY: begin
                  status_in = pok_ff ? lob_pkg::ST_OK : lob_pkg::ST_BAD_PRICE;
                  state_in = pok_ff ? lob_pkg::S_LVL_RD : lob_pkg::S_RESP;
               end
               default: begin
                  if (id_bad) begin
                     status_in = lob_pkg::ST_BAD_ID;
                     state_in = lob_pkg::S_RESP;
                  end else if (!live_rd) begin
                     status_in = lob_pkg::ST_NOT_FOUND;
                     state_in = lob_pkg::S_RESP;
                  end else begin
                     side_in = oinfo_rd[SW];
                     slot_in = oinfo_rd[SW-1:0];
                     state_in = lob_pkg::S_ORD_RD;
                  end
               end
            endcase
         end
         lob_pkg::S_ORD_RD: begin
            // level read at the stored slot
            state_in = lob_pkg::S_REMOVE;
         end
         lob_pkg::S_LVL_RD: begin
            status_in = lob_pkg::ST_OK;
            if (req_ff.func == lob_pkg::FN_QUERY) begin
               lq_in = lvl_rd;
            end else if (lvl_rd == 32'd0 && act_ff >= AW'(LEVEL_POOL)) begin
               status_in = lob_pkg::ST_FULL;
            end else if (sum[32]) begin
               status_in = lob_pkg::ST_BAD_QTY;
            end else begin
               if (lvl_rd == 32'd0) act_in = act_ff + AW'(1);
               lvl_wd = sum[31:0];
               bid_we = !side_ff;
               ask_we = side_ff;
               live_we = 1'b1;
               live_wd = 1'b1;
               oinfo_we = 1'b1;
               orem_we = 1'b1;
               if (!side_ff) begin
                  if (bbid_ff == none_mark || {1'b0, slot_ff} > bbid_ff)
                     bbid_in = {1'b0, slot_ff};
               end else begin
                  if (bask_ff == none_mark || {1'b0, slot_ff} < bask_ff)
                     bask_in = {1'b0, slot_ff};
               end
            end
            state_in = lob_pkg::S_RESP;
         end
         lob_pkg::S_REMOVE: begin
            status_in = lob_pkg::ST_OK;
            state_in = lob_pkg::S_RESP;
            bid_we = !side_ff;
            ask_we = side_ff;
            if (req_ff.func == lob_pkg::FN_EXEC && req_ff.quantity < orem_rd) begin
               orem_we = 1'b1;
               orem_wd = orem_rd - req_ff.quantity;
               lvl_wd = lvl_rd - req_ff.quantity;
            end else begin
               newtot = lvl_rd - orem_rd;
               lvl_wd = newtot;
               live_we = 1'b1;
               live_wd = 1'b0;
               if (newtot == 32'd0) begin
                  if (act_ff != '0) act_in = act_ff - AW'(1);
                  if (!side_ff && bbid_ff == {1'b0, slot_ff}) begin
                     bbid_in = none_mark;
                     scan_in = slot_ff;
                     state_in = lob_pkg::S_SCAN;
                  end else if (side_ff && bask_ff == {1'b0, slot_ff}) begin
                     bask_in = none_mark;
                     scan_in = slot_ff;
                     state_in = lob_pkg::S_SCAN;
                  end
               end
            end
         end
         lob_pkg::S_SCAN: begin
            // the emptied slot itself is zero; step outward from it
            if ((!side_ff && scan_ff == '0) ||
                (side_ff && scan_ff == SW'(PRICE_SPAN - 1))) begin
               state_in = lob_pkg::S_RESP;
            end else begin
               scan_in = side_ff ? scan_ff + SW'(1) : scan_ff - SW'(1);
               state_in = lob_pkg::S_SCAN_CHK;
            end
         end
         lob_pkg::S_SCAN_CHK: begin
            laddr = scan_ff;
            state_in = lob_pkg::S_SCAN;
         end
         lob_pkg::S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_in.status = status_ff;
               rsp_in.bid_present = bbid_ff != none_mark;
               rsp_in.best_bid_price = (bbid_ff != none_mark)
                  ? base_ff + {{(31-SW){1'b0}}, bbid_ff} : 32'd0;
               rsp_in.ask_present = bask_ff != none_mark;
               rsp_in.best_ask_price = (bask_ff != none_mark)
                  ? base_ff + {{(31-SW){1'b0}}, bask_ff} : 32'd0;
               rsp_in.level_quantity = lq_ff;
               state_in = lob_pkg::S_IDLE;
            end
         end
         default: state_in = lob_pkg::S_IDLE;
      endcase
      // scan: read issued in S_SCAN_CHK at scan_ff; data checked in next S_SCAN
      if (state_ff == lob_pkg::S_SCAN && scan_ff != slot_ff && lvl_rd != 32'd0) begin
         if (!side_ff) bbid_in = {1'b0, scan_ff};
         else bask_in = {1'b0, scan_ff};
         state_in = lob_pkg::S_RESP;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> state_ff == lob_pkg::S_IDLE)
      else $error("ready outside idle");
   a_active_cap: assert property (@(posedge clock) disable iff (reset)
      act_ff <= AW'(LEVEL_POOL))
      else $error("level count over pool");
   a_best_range: assert property (@(posedge clock) disable iff (reset)
      bbid_ff <= none_mark && bask_ff <= none_mark)
      else $error("best slot out of range");

endmodule

### tb/limit_order_book_tb.sv
// Self-checking testbench for limit_order_book: directed and random book operations,
// checked against a behavioural book model held in the bench. Depends on lob_pkg and limit_order_book.
`timescale 1ns / 1ps
module limit_order_book_tb;

   localparam int unsigned NSLOT = 1024;
   localparam int unsigned NPOOL = 1024;
   localparam int unsigned NSPAN = 1024;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   lob_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   lob_pkg::rsp_type rsp_data;
   logic csr_write = 1'b0;
   logic [0:0] csr_index = lob_pkg::CSR_BASE_PRICE;
   logic [lob_pkg::CSR_WIDTH-1:0] csr_data = '0;

   limit_order_book dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   always #2 clock = ~clock;

   // book model
   logic [31:0] base_px;
   logic [10:0] px_range;
   bit          live [NSLOT];
   bit          ord_side [NSLOT];
   int unsigned ord_slot [NSLOT];
   logic [31:0] ord_left [NSLOT];
   logic [31:0] lvl_tot [2][NSPAN];
   int unsigned n_levels;
   int unsigned top_bid, top_ask;

   lob_pkg::rsp_type pending_rsp[$];
   int          errors = 0;
   int          send_idle = 0;   // percent
   int          recv_stall = 0;  // percent

   function automatic bit px_to_slot(input logic [31:0] px, output int unsigned slot);
      int unsigned lim;
      lim = (px_range > NSPAN) ? NSPAN : px_range;
      slot = 0;
      if (px == 0 || px == 32'hFFFF_FFFF || px < base_px) return 0;
      if (px - base_px >= lim) return 0;
      slot = px - base_px;
      return 1;
   endfunction

   function automatic void find_best(input bit s);
      if (!s) begin
         top_bid = NSPAN;
         for (int i = NSPAN - 1; i >= 0; i--)
            if (lvl_tot[0][i] != 0) begin top_bid = i; break; end
      end else begin
         top_ask = NSPAN;
         for (int i = 0; i < NSPAN; i++)
            if (lvl_tot[1][i] != 0) begin top_ask = i; break; end
      end
   endfunction

   function automatic lob_pkg::status_type book_add(input lob_pkg::req_type r);
      int unsigned slot;
      if (r.order_id >= NSLOT) return lob_pkg::ST_BAD_ID;
      if (!px_to_slot(r.price, slot)) return lob_pkg::ST_BAD_PRICE;
      if (r.quantity == 0) return lob_pkg::ST_BAD_QTY;
      if (live[r.order_id]) return lob_pkg::ST_DUP;
      if (lvl_tot[r.side][slot] == 0) begin
         if (n_levels >= NPOOL) return lob_pkg::ST_FULL;
      end else if (lvl_tot[r.side][slot] > 32'hFFFF_FFFF - r.quantity)
         return lob_pkg::ST_BAD_QTY;
      if (lvl_tot[r.side][slot] == 0) n_levels++;
      lvl_tot[r.side][slot] += r.quantity;
      live[r.order_id] = 1;
      ord_side[r.order_id] = r.side;
      ord_slot[r.order_id] = slot;
      ord_left[r.order_id] = r.quantity;
      if (!r.side) begin
         if (top_bid == NSPAN || slot > top_bid) top_bid = slot;
      end else if (top_ask == NSPAN || slot < top_ask) top_ask = slot;
      return lob_pkg::ST_OK;
   endfunction

   function automatic lob_pkg::status_type book_remove(input lob_pkg::req_type r,
                                                       input bit exec);
      bit s;
      int unsigned slot;
      logic [31:0] q;
      if (r.order_id >= NSLOT) return lob_pkg::ST_BAD_ID;
      if (!live[r.order_id]) return lob_pkg::ST_NOT_FOUND;
      s = ord_side[r.order_id];
      slot = ord_slot[r.order_id];
      if (exec && r.quantity < ord_left[r.order_id]) begin
         ord_left[r.order_id] -= r.quantity;
         lvl_tot[s][slot] -= r.quantity;
         return lob_pkg::ST_OK;
      end
      q = ord_left[r.order_id];
      lvl_tot[s][slot] -= q;
      if (lvl_tot[s][slot] == 0) begin
         if (n_levels > 0) n_levels--;
         if ((!s && top_bid == slot) || (s && top_ask == slot)) find_best(s);
      end
      live[r.order_id] = 0;
      ord_left[r.order_id] = 0;
      return lob_pkg::ST_OK;
   endfunction

   function automatic lob_pkg::rsp_type book_step(input lob_pkg::req_type r);
      lob_pkg::rsp_type o;
      int unsigned slot;
      o = '0;
      case (lob_pkg::func_type'(r.func))
         lob_pkg::FN_ADD:    o.status = book_add(r);
         lob_pkg::FN_CANCEL: o.status = book_remove(r, 0);
         lob_pkg::FN_EXEC:   o.status = book_remove(r, 1);
         default: begin
            if (px_to_slot(r.price, slot)) begin
               o.level_quantity = lvl_tot[r.side][slot];
               o.status = lob_pkg::ST_OK;
            end else o.status = lob_pkg::ST_BAD_PRICE;
         end
      endcase
      if (top_bid != NSPAN) begin
         o.best_bid_price = base_px + top_bid;
         o.bid_present = 1;
      end
      if (top_ask != NSPAN) begin
         o.best_ask_price = base_px + top_ask;
         o.ask_present = 1;
      end
      return o;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
      errors++;
   endtask

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rsp.size() == 0) report_mismatch("unexpected transfer", 0, 0);
         else begin
            lob_pkg::rsp_type w;
            w = pending_rsp.pop_front();
            if (rsp_data.status != w.status)
               report_mismatch("status", rsp_data.status, w.status);
            if (rsp_data.best_bid_price != w.best_bid_price)
               report_mismatch("best_bid_price", rsp_data.best_bid_price, w.best_bid_price);
            if (rsp_data.bid_present != w.bid_present)
               report_mismatch("bid_present", rsp_data.bid_present, w.bid_present);
            if (rsp_data.best_ask_price != w.best_ask_price)
               report_mismatch("best_ask_price", rsp_data.best_ask_price, w.best_ask_price);
            if (rsp_data.ask_present != w.ask_present)
               report_mismatch("ask_present", rsp_data.ask_present, w.ask_present);
            if (rsp_data.level_quantity != w.level_quantity)
               report_mismatch("level_quantity", rsp_data.level_quantity, w.level_quantity);
         end
      end
   end

   always @(posedge clock)
      rsp_ready <= ($urandom_range(99) >= recv_stall);

   task automatic send_order(input lob_pkg::func_type f, input int unsigned id, input bit s,
                             input logic [31:0] px, input logic [31:0] q);
      lob_pkg::req_type r;
      r.func = f;
      r.order_id = id;
      r.side = s;
      r.price = px;
      r.quantity = q;
      while ($urandom_range(99) < send_idle) @(posedge clock);
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_rsp.push_back(book_step(r));
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic drain_book();
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_csr(input logic [0:0] idx, input logic [31:0] v);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= v;
      @(posedge clock);
      csr_write <= 1'b0;
      if (idx == lob_pkg::CSR_BASE_PRICE) base_px = v;
      else px_range = v[10:0];
      @(posedge clock);
   endtask

   function automatic logic [31:0] rand_px();
      int unsigned lim;
      lim = (px_range > NSPAN) ? NSPAN : px_range;
      case ($urandom_range(9))
         0: return $urandom();
         1: return base_px + lim;
         2: return base_px - 1;
         default: return base_px + $urandom_range(lim == 0 ? 0 : lim - 1);
      endcase
   endfunction

   function automatic logic [31:0] rand_qty();
      case ($urandom_range(7))
         0: return $urandom();
         1: return 0;
         2: return 32'hFFFF_FFFF - $urandom_range(3);
         default: return $urandom_range(1, 1000);
      endcase
   endfunction

   task automatic test_directed();
      send_order(lob_pkg::FN_QUERY, 0, 0, 5, 0);
      send_order(lob_pkg::FN_ADD, 4095, 0, 5, 1);
      send_order(lob_pkg::FN_ADD, 1, 0, 0, 1);
      send_order(lob_pkg::FN_ADD, 1, 0, 32'hFFFF_FFFF, 1);
      send_order(lob_pkg::FN_ADD, 1, 0, 1024, 1);
      send_order(lob_pkg::FN_ADD, 1, 0, 10, 0);
      send_order(lob_pkg::FN_ADD, 1, 0, 10, 32'hFFFF_FFF0);
      send_order(lob_pkg::FN_ADD, 2, 0, 10, 32'h20);
      send_order(lob_pkg::FN_ADD, 1, 1, 10, 5);
      send_order(lob_pkg::FN_ADD, 1023, 1, 1023, 7);
      send_order(lob_pkg::FN_ADD, 3, 1, 1, 7);
      send_order(lob_pkg::FN_ADD, 4, 0, 1023, 9);
      send_order(lob_pkg::FN_QUERY, 4000, 0, 10, 0);
      send_order(lob_pkg::FN_QUERY, 0, 1, 32'hFFFF_FFFF, 0);
      send_order(lob_pkg::FN_EXEC, 1, 1, 0, 32'h10);
      send_order(lob_pkg::FN_EXEC, 1, 0, 0, 0);
      send_order(lob_pkg::FN_EXEC, 4, 0, 0, 32'hFFFF_FFFF);
      send_order(lob_pkg::FN_CANCEL, 3, 0, 0, 0);
      send_order(lob_pkg::FN_CANCEL, 3, 0, 0, 0);
      send_order(lob_pkg::FN_CANCEL, 4095, 0, 0, 0);
      send_order(lob_pkg::FN_EXEC, 2048, 0, 0, 1);
      send_order(lob_pkg::FN_CANCEL, 1, 0, 0, 0);
      send_order(lob_pkg::FN_CANCEL, 1023, 0, 0, 0);
      send_order(lob_pkg::FN_ADD, 5, 0, 1000, 3); // bid placed with nothing left on the ask side
      send_order(lob_pkg::FN_ADD, 6, 1, 2, 3);
   endtask

   // mostly well-formed adds, cancels, executes and queries on a small id set
   task automatic test_random(input int n);
      int unsigned id, f;
      for (int i = 0; i < n; i++) begin
         f = $urandom_range(9);
         id = ($urandom_range(19) == 0) ? $urandom_range(4095) : $urandom_range(63);
         if ($urandom_range(39) == 0) id = 1023;
         if (f < 4) send_order(lob_pkg::FN_ADD, id, $urandom_range(1), rand_px(), rand_qty());
         else if (f < 6) send_order(lob_pkg::FN_CANCEL, id, $urandom_range(1), $urandom(),
                                    $urandom());
         else if (f < 8) send_order(lob_pkg::FN_EXEC, id, $urandom_range(1), $urandom(),
                                    ($urandom_range(1) ? $urandom_range(0, 600) : rand_qty()));
         else send_order(lob_pkg::FN_QUERY, $urandom_range(4095), $urandom_range(1), rand_px(),
                         $urandom());
      end
   endtask

   // many levels on both sides, then cleared again, forcing long scans
   task automatic test_many_levels();
      for (int i = 0; i < 256; i++)
         send_order(lob_pkg::FN_ADD, i, i[0], base_px + 32'(4 * i), 1 + (i >> 7));
      for (int i = 0; i < 256; i++)
         send_order(lob_pkg::FN_CANCEL, i, 0, 0, 0);
   endtask

   initial begin
      base_px = 0;
      px_range = 11'd1024;
      for (int i = 0; i < NSLOT; i++) begin
         live[i] = 0;
         ord_side[i] = 0;
         ord_slot[i] = 0;
         ord_left[i] = 0;
      end
      for (int i = 0; i < NSPAN; i++) begin
         lvl_tot[0][i] = 0;
         lvl_tot[1][i] = 0;
      end
      n_levels = 0;
      top_bid = NSPAN;
      top_ask = NSPAN;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      test_random(150);
      drain_book();                       // sender holds off until all results are in
      send_idle = 83;
      test_random(100);
      drain_book();
      write_csr(lob_pkg::CSR_BASE_PRICE, 32'hFFFF_FF00);
      write_csr(lob_pkg::CSR_PRICE_RANGE, 11'd1);
      send_idle = 0;
      recv_stall = 83;
      test_random(100);
      drain_book();
      write_csr(lob_pkg::CSR_PRICE_RANGE, 11'd0);
      test_random(40);
      drain_book();
      write_csr(lob_pkg::CSR_PRICE_RANGE, 11'd2047);
      write_csr(lob_pkg::CSR_BASE_PRICE, 32'd1000);
      send_idle = 14;
      recv_stall = 14;
      test_random(200);
      drain_book();
      write_csr(lob_pkg::CSR_PRICE_RANGE, 11'd40);
      write_csr(lob_pkg::CSR_BASE_PRICE, 32'd0);
      send_idle = 0;
      recv_stall = 0;
      test_random(350);
      drain_book();
      write_csr(lob_pkg::CSR_PRICE_RANGE, 11'd1024);
      write_csr(lob_pkg::CSR_BASE_PRICE, 32'h8000_0000);
      test_random(250);
      drain_book();
      test_many_levels();
      drain_book();
      write_csr(lob_pkg::CSR_BASE_PRICE, 32'd50);
      recv_stall = 30;
      test_random(200);
      drain_book();

      if (errors == 0) $display("All tests passed");
      else $display("Some tests failed");
      $finish;
   end

   initial begin
      #100_000_000;
      $display("Some tests failed");
      $finish;
   end
endmodule

### sim.f
design/lob_pkg.sv
design/limit_order_book.sv
tb/limit_order_book_tb.sv
